// ----- rtl/sbt_pkg.sv -----
// Shared widths, register indexes, types and reset values for the swing Bezier point block.
package sbt_pkg;

  localparam int IN_W      = 20;
  localparam int PH_W      = 17;
  localparam int LEG_W     = 2;
  localparam int DIR_W     = 48;
  localparam int LANE_W    = 16;
  localparam int HR_W      = 15;
  localparam int LR_W      = 16;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [PH_W-1:0] PHASE_ONE  = 17'd65536;
  localparam logic [PH_W-1:0] PHASE_HALF = 17'd32768;

  // chord length square root
  localparam int DIFF_W      = IN_W + 1;
  localparam int SQ_IN_W     = 2 * DIFF_W;
  localparam int SQ_OUT_W    = DIFF_W;
  localparam int SQ_STEPS    = 3;
  localparam int SQ_STAGES   = SQ_OUT_W / SQ_STEPS;
  localparam int SQ_REM_W    = SQ_OUT_W + 3;

  // pipeline depth: setup, square root, lift, curve and saturation stages
  localparam int LAT = SQ_STAGES + 13;

  // handle and lift offsets
  localparam int HP_W   = HR_W + 1 + DIFF_W;
  localparam int HOFF_W = HP_W - 14;
  localparam int LSC_W  = LR_W + SQ_OUT_W;
  localparam int LO_W   = 19;
  localparam int HI_W   = LSC_W - LO_W;
  localparam int LPL_W  = LANE_W + LO_W + 1;
  localparam int LPH_W  = LANE_W + HI_W + 1;
  localparam int LP_W   = LANE_W + LSC_W + 1;
  localparam int LOFF_W = LP_W - 28;

  // curve evaluation
  localparam int CW   = 27;
  localparam int LM_W = CW + 1 + PH_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRONT_DIR1   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_DIR2   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIND_DIR1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIND_DIR2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_HANDLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_LIFT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIND_HANDLE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HIND_LIFT    = 3'd7;

  localparam logic [DIR_W-1:0] DIR_RESET    = 48'h4000_0000_0000;
  localparam logic [HR_W-1:0]  HANDLE_RESET = 15'd8192;
  localparam logic [LR_W-1:0]  LIFT_RESET   = 16'd8192;

  localparam logic signed [CW-1:0] COORD_MAX = 27'sd524287;
  localparam logic signed [CW-1:0] COORD_MIN = -27'sd524288;

  typedef logic signed [CW-1:0]   coord_t;
  typedef logic signed [LM_W-1:0] lm_t;

  typedef struct packed {
    logic [2:0][IN_W-1:0]     a;
    logic [2:0][IN_W-1:0]     b;
    logic [PH_W-1:0]          t;
    logic                     seg;
    logic                     hind;
    logic signed [HOFF_W-1:0] hoff;
  } side_t;

endpackage

// ----- rtl/swing_bezier_trajectory_point.sv -----
// Top level: two-segment cubic Bezier swing path point, fully pipelined.
//
// One item in, one point out. The block takes a new item every clock while
// the output is not held; each result passes through 3 setup stages, 7
// square-root stages at 3 root bits each, 3 stages for the lift scale,
// lift products and control points, 6 stages for the three de Casteljau
// levels and 1 saturation stage. The whole pipe advances together: when the
// output holds an item that is not taken, every stage holds and in_ready
// drops, so nothing is lost or repeated. Configuration registers are read
// directly by the stages that need them; write them only while the pipe
// is empty.
module swing_bezier_trajectory_point import sbt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_W-1:0]      start_x,
  input  logic [IN_W-1:0]      start_y,
  input  logic [IN_W-1:0]      start_z,
  input  logic [IN_W-1:0]      mid_x,
  input  logic [IN_W-1:0]      mid_y,
  input  logic [IN_W-1:0]      mid_z,
  input  logic [IN_W-1:0]      end_x,
  input  logic [IN_W-1:0]      end_y,
  input  logic [IN_W-1:0]      end_z,
  input  logic [PH_W-1:0]      phase,
  input  logic [LEG_W-1:0]     leg,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IN_W-1:0]      pos_x,
  output logic [IN_W-1:0]      pos_y,
  output logic [IN_W-1:0]      pos_z,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  // ---------------- configuration registers ----------------
  logic [DIR_W-1:0] dir_cfg [4];
  logic [HR_W-1:0]  handle_front, handle_hind;
  logic [LR_W-1:0]  lift_front, lift_hind;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) dir_cfg[i] <= DIR_RESET;
      handle_front <= HANDLE_RESET;
      handle_hind  <= HANDLE_RESET;
      lift_front   <= LIFT_RESET;
      lift_hind    <= LIFT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FRONT_DIR1:   dir_cfg[0]   <= cfg_data;
        REG_FRONT_DIR2:   dir_cfg[1]   <= cfg_data;
        REG_HIND_DIR1:    dir_cfg[2]   <= cfg_data;
        REG_HIND_DIR2:    dir_cfg[3]   <= cfg_data;
        REG_FRONT_HANDLE: handle_front <= cfg_data[HR_W-1:0];
        REG_FRONT_LIFT:   lift_front   <= cfg_data[LR_W-1:0];
        REG_HIND_HANDLE:  handle_hind  <= cfg_data[HR_W-1:0];
        REG_HIND_LIFT:    lift_hind    <= cfg_data[LR_W-1:0];
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // One valid bit per stage; the pipe moves as a whole.
  logic [LAT-1:0] vld;
  logic           en;

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // ---------------- stage 1: segment select, t ----------------
  logic [PH_W-1:0] ph_c;
  logic            seg_c;
  logic [PH_W:0]   ph2;
  logic [PH_W:0]   t_full;
  side_t           s1_next, s1;

  always_comb begin
    ph_c   = (phase > PHASE_ONE) ? PHASE_ONE : phase;
    seg_c  = (ph_c >= PHASE_HALF);
    ph2    = {ph_c, 1'b0};
    t_full = seg_c ? (ph2 - {1'b0, PHASE_ONE}) : ph2;
    s1_next.t    = t_full[PH_W-1:0];
    s1_next.seg  = seg_c;
    s1_next.hind = leg[1];
    s1_next.hoff = '0;
    // segment one runs start to middle, segment two middle to end
    s1_next.a = seg_c ? {mid_z, mid_y, mid_x} : {start_z, start_y, start_x};
    s1_next.b = seg_c ? {end_z, end_y, end_x} : {mid_z, mid_y, mid_x};
  end

  always_ff @(posedge clk) begin
    if (en) s1 <= s1_next;
  end

  // ---------------- stage 2: squares, handle product ----------------
  side_t                     s2;
  logic [SQ_IN_W-1:0]        sq [3];
  logic signed [HP_W-1:0]    hprod;
  logic signed [DIFF_W-1:0]  dd [3];
  logic signed [DIFF_W-1:0]  hdiff;
  logic [HR_W-1:0]           hsel;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i] = $signed({s1.a[i][IN_W-1], s1.a[i]}) - $signed({s1.b[i][IN_W-1], s1.b[i]});
    end
    hdiff = $signed({s1.b[0][IN_W-1], s1.b[0]}) - $signed({s1.a[0][IN_W-1], s1.a[0]});
    hsel  = s1.hind ? handle_hind : handle_front;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s1;
      for (int i = 0; i < 3; i++) sq[i] <= SQ_IN_W'(dd[i] * dd[i]);
      hprod <= HP_W'($signed({1'b0, hsel})) * HP_W'(hdiff);
    end
  end

  // ---------------- stage 3: sum of squares, rounded handle ----------------
  side_t                  s3, s3_next;
  logic [SQ_IN_W-1:0]     sum_sq;
  logic signed [HP_W-1:0] hprod_r;

  assign hprod_r = hprod + HP_W'(8192);

  always_comb begin
    s3_next      = s2;
    s3_next.hoff = hprod_r[HP_W-1:14];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3     <= s3_next;
      sum_sq <= sq[0] + sq[1] + sq[2];
    end
  end

  // ---------------- chord length ----------------
  logic [SQ_OUT_W-1:0] len;
  side_t               sd [SQ_STAGES];

  sbt_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum_sq),
    .root (len)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= s3;
      for (int k = 1; k < SQ_STAGES; k++) sd[k] <= sd[k-1];
    end
  end

  // ---------------- lift scale ----------------
  side_t            s11;
  logic [LSC_W-1:0] scale;
  logic [LR_W-1:0]  lsel;

  assign lsel = sd[SQ_STAGES-1].hind ? lift_hind : lift_front;

  always_ff @(posedge clk) begin
    if (en) begin
      s11   <= sd[SQ_STAGES-1];
      scale <= LSC_W'(lsel) * LSC_W'(len);
    end
  end

  // ---------------- lift products, split in two partials ----------------
  side_t                    s12;
  logic signed [LPL_W-1:0]  lpl [3];
  logic signed [LPH_W-1:0]  lph [3];
  logic [DIR_W-1:0]         dsel;

  assign dsel = dir_cfg[{s11.hind, s11.seg}];

  always_ff @(posedge clk) begin
    if (en) begin
      s12 <= s11;
      for (int i = 0; i < 3; i++) begin
        lpl[i] <= LPL_W'($signed(dsel[LANE_W*i +: LANE_W]))
                  * LPL_W'($signed({1'b0, scale[LO_W-1:0]}));
        lph[i] <= LPH_W'($signed(dsel[LANE_W*i +: LANE_W]))
                  * LPH_W'($signed({1'b0, scale[LSC_W-1:LO_W]}));
      end
    end
  end

  // ---------------- control points ----------------
  coord_t                   cp [3][4];
  logic [PH_W-1:0]          t_cp;
  logic signed [LP_W-1:0]   lprod [3];
  logic signed [LOFF_W-1:0] loff [3];
  coord_t                   cp_next [3][4];
  coord_t                   av, bv, lp;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lprod[i] = (LP_W'(lph[i]) <<< LO_W) + LP_W'(lpl[i]) + LP_W'(134217728);
      loff[i]  = lprod[i][LP_W-1:28];
      av = CW'($signed(s12.a[i]));
      bv = CW'($signed(s12.b[i]));
      lp = (s12.seg ? bv : av) + CW'(loff[i]);
      cp_next[i][0] = av;
      cp_next[i][3] = bv;
      if (s12.seg) begin
        cp_next[i][1] = (i == 0) ? av + CW'(s12.hoff) : av;
        cp_next[i][2] = lp;
      end else begin
        cp_next[i][1] = lp;
        cp_next[i][2] = (i == 0) ? bv - CW'(s12.hoff) : bv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp   <= cp_next;
      t_cp <= s12.t;
    end
  end

  // ---------------- de Casteljau, three levels of mul then add ----------------
  function automatic lm_t lerp_mul(coord_t p, coord_t q, logic [PH_W-1:0] t);
    logic signed [CW:0] d;
    d = {q[CW-1], q} - {p[CW-1], p};
    return LM_W'(d) * LM_W'($signed({1'b0, t}));
  endfunction

  function automatic coord_t lerp_add(coord_t base, lm_t m);
    lm_t r;
    r = m + LM_W'(32768);
    return base + $signed(r[CW+15:16]);
  endfunction

  coord_t          b1 [3][3], r1 [3][3];
  lm_t             m1 [3][3];
  coord_t          b2 [3][2], r2 [3][2];
  lm_t             m2 [3][2];
  coord_t          b3 [3], r3 [3];
  lm_t             m3 [3];
  logic [PH_W-1:0] t_1a, t_1b, t_2a, t_2b;

  always_ff @(posedge clk) begin
    if (en) begin
      t_1a <= t_cp;
      t_1b <= t_1a;
      t_2a <= t_1b;
      t_2b <= t_2a;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          b1[i][j] <= cp[i][j];
          m1[i][j] <= lerp_mul(cp[i][j], cp[i][j+1], t_cp);
          r1[i][j] <= lerp_add(b1[i][j], m1[i][j]);
        end
        for (int j = 0; j < 2; j++) begin
          b2[i][j] <= r1[i][j];
          m2[i][j] <= lerp_mul(r1[i][j], r1[i][j+1], t_1b);
          r2[i][j] <= lerp_add(b2[i][j], m2[i][j]);
        end
        b3[i] <= r2[i][0];
        m3[i] <= lerp_mul(r2[i][0], r2[i][1], t_2b);
        r3[i] <= lerp_add(b3[i], m3[i]);
      end
    end
  end

  // ---------------- saturation / output register ----------------
  logic [IN_W-1:0] pos [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (r3[i] > COORD_MAX)      pos[i] <= COORD_MAX[IN_W-1:0];
        else if (r3[i] < COORD_MIN) pos[i] <= COORD_MIN[IN_W-1:0];
        else                        pos[i] <= r3[i][IN_W-1:0];
      end
    end
  end

  assign pos_x = pos[0];
  assign pos_y = pos[1];
  assign pos_z = pos[2];

  // ---------------- assertions ----------------
  a_rst_clears: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("valid bits moved during a stall");

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (s1.t <= PHASE_ONE) && (s1.seg || (s1.t < PHASE_ONE)))
    else $error("segment parameter out of range");

endmodule

// ----- rtl/sbt_isqrt.sv -----
// Pipelined floor square root, SQ_STEPS result bits per stage.
module sbt_isqrt import sbt_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SQ_IN_W-1:0]  rad,
  output logic [SQ_OUT_W-1:0] root
);

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_OUT_W-1:0] root;
    logic [SQ_IN_W-1:0]  rad;
  } sq_st_t;

  sq_st_t st [SQ_STAGES];
  sq_st_t st_next [SQ_STAGES];

  function automatic sq_st_t sq_step(sq_st_t s);
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_REM_W-1:0] trial;
    sq_st_t o;
    rem   = {s.rem[SQ_REM_W-3:0], s.rad[SQ_IN_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    o.rad = {s.rad[SQ_IN_W-3:0], 2'b00};
    if (rem >= trial) begin
      o.rem  = rem - trial;
      o.root = {s.root[SQ_OUT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem;
      o.root = {s.root[SQ_OUT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    sq_st_t cur;
    for (int g = 0; g < SQ_STAGES; g++) begin
      if (g == 0) begin
        cur.rem  = '0;
        cur.root = '0;
        cur.rad  = rad;
      end else begin
        cur = st[g-1];
      end
      for (int k = 0; k < SQ_STEPS; k++) begin
        cur = sq_step(cur);
      end
      st_next[g] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < SQ_STAGES; g++) begin
        st[g] <= st_next[g];
      end
    end
  end

  assign root = st[SQ_STAGES-1].root;

endmodule

// ----- verif/sbt_point_checker.sv -----
// Checker for the swing Bezier point block: mirrors the registers, predicts each point, compares.
module sbt_point_checker import sbt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [IN_W-1:0]      start_x,
  input  logic [IN_W-1:0]      start_y,
  input  logic [IN_W-1:0]      start_z,
  input  logic [IN_W-1:0]      mid_x,
  input  logic [IN_W-1:0]      mid_y,
  input  logic [IN_W-1:0]      mid_z,
  input  logic [IN_W-1:0]      end_x,
  input  logic [IN_W-1:0]      end_y,
  input  logic [IN_W-1:0]      end_z,
  input  logic [PH_W-1:0]      phase,
  input  logic [LEG_W-1:0]     leg,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [IN_W-1:0]      pos_x,
  input  logic [IN_W-1:0]      pos_y,
  input  logic [IN_W-1:0]      pos_z,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [2:0][IN_W-1:0] point_t;

  logic [DIR_W-1:0] dir_reg [4];
  logic [HR_W-1:0]  handle_front, handle_hind;
  logic [LR_W-1:0]  lift_front, lift_hind;
  point_t           point_q [$];

  // floor((v + 2^(s-1)) / 2^s)
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint chord_len(longint a [3], longint b [3]);
    longint unsigned x, r, bitv;
    longint d;
    x = 0;
    for (int i = 0; i < 3; i++) begin
      d = a[i] - b[i];
      x += longint'(d * d);
    end
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint interp(longint a, longint b, longint t);
    return a + round_shift((b - a) * t, 16);
  endfunction

  function automatic point_t predict_point(point_t s_in, point_t m_in, point_t e_in,
                                           logic [PH_W-1:0] ph, logic [LEG_W-1:0] lg);
    longint s [3], m [3], e [3], p0 [3], p1 [3], p2 [3], p3 [3];
    longint t, len, scale, lane, a, b, c, v;
    logic hind;
    logic [DIR_W-1:0] dir;
    longint h, lr;
    point_t res;
    hind = lg[1];
    h  = longint'(hind ? handle_hind : handle_front);
    lr = longint'(hind ? lift_hind : lift_front);
    for (int i = 0; i < 3; i++) begin
      s[i] = longint'($signed(s_in[i]));
      m[i] = longint'($signed(m_in[i]));
      e[i] = longint'($signed(e_in[i]));
    end
    if (ph > PHASE_ONE) ph = PHASE_ONE;
    if (ph < PHASE_HALF) begin
      t = 2 * longint'(ph);
      dir = dir_reg[hind ? REG_HIND_DIR1 : REG_FRONT_DIR1];
      len = chord_len(s, m);
      scale = lr * len;
      for (int i = 0; i < 3; i++) begin
        lane = longint'($signed(dir[16*i +: 16]));
        p0[i] = s[i];
        p1[i] = s[i] + round_shift(lane * scale, 28);
        p2[i] = m[i];
        p3[i] = m[i];
      end
      p2[0] = m[0] - round_shift(h * (m[0] - s[0]), 14);
    end else begin
      t = 2 * longint'(ph) - 65536;
      dir = dir_reg[hind ? REG_HIND_DIR2 : REG_FRONT_DIR2];
      len = chord_len(m, e);
      scale = lr * len;
      for (int i = 0; i < 3; i++) begin
        lane = longint'($signed(dir[16*i +: 16]));
        p0[i] = m[i];
        p1[i] = m[i];
        p2[i] = e[i] + round_shift(lane * scale, 28);
        p3[i] = e[i];
      end
      p1[0] = m[0] + round_shift(h * (e[0] - m[0]), 14);
    end
    for (int i = 0; i < 3; i++) begin
      a = interp(p0[i], p1[i], t);
      b = interp(p1[i], p2[i], t);
      c = interp(p2[i], p3[i], t);
      v = interp(interp(a, b, t), interp(b, c, t), t);
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      res[i] = v[IN_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    point_t want, got;
    if (rst) begin
      for (int i = 0; i < 4; i++) dir_reg[i] = DIR_RESET;
      handle_front = HANDLE_RESET;
      handle_hind  = HANDLE_RESET;
      lift_front   = LIFT_RESET;
      lift_hind    = LIFT_RESET;
      point_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_FRONT_DIR1, REG_FRONT_DIR2,
          REG_HIND_DIR1, REG_HIND_DIR2: dir_reg[cfg_idx[1:0]] = cfg_data[DIR_W-1:0];
          REG_FRONT_HANDLE: handle_front = cfg_data[HR_W-1:0];
          REG_FRONT_LIFT:   lift_front   = cfg_data[LR_W-1:0];
          REG_HIND_HANDLE:  handle_hind  = cfg_data[HR_W-1:0];
          REG_HIND_LIFT:    lift_hind    = cfg_data[LR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        point_q.push_back(predict_point({start_z, start_y, start_x}, {mid_z, mid_y, mid_x},
                                        {end_z, end_y, end_x}, phase, leg));
      if (out_valid && out_ready) begin
        got = {pos_z, pos_y, pos_x};
        if (point_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected point out: %h %h %h", pos_x, pos_y, pos_z);
        end else begin
          want = point_q.pop_front();
          if (want != got) begin
            fail_count++;
            if (fail_count <= 10)
              $display("point mismatch: exp x=%h y=%h z=%h got x=%h y=%h z=%h",
                       want[0], want[1], want[2], got[0], got[1], got[2]);
          end
        end
      end
    end
    pending = point_q.size();
  end

endmodule

// ----- verif/tb_swing_bezier_trajectory_point.sv -----
// Testbench top: stimulus, register phases, backpressure and verdict for the swing point block.
module tb_swing_bezier_trajectory_point;
  import sbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [IN_W-1:0]  s [3];
    logic [IN_W-1:0]  m [3];
    logic [IN_W-1:0]  e [3];
    logic [PH_W-1:0]  ph;
    logic [LEG_W-1:0] lg;
  } swing_req_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_we = 0;
  logic [IN_W-1:0] start_x = 0, start_y = 0, start_z = 0;
  logic [IN_W-1:0] mid_x = 0, mid_y = 0, mid_z = 0;
  logic [IN_W-1:0] end_x = 0, end_y = 0, end_z = 0;
  logic [PH_W-1:0] phase = 0;
  logic [LEG_W-1:0] leg = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = 0;
  logic [CFG_W-1:0] cfg_data = 0;
  logic in_ready, out_valid;
  logic [IN_W-1:0] pos_x, pos_y, pos_z;
  logic in_taken = 0;          // registered view of the input handshake, read at negedge
  int fail_count, pending;
  int n_sent = 0;
  int burst_left = 0;
  int stall_left = 0;
  bit long_stall_done = 0;

  always #10 clk = ~clk;

  swing_bezier_trajectory_point uut (.*);
  sbt_point_checker chk (.*);

  always @(posedge clk) in_taken <= in_valid && in_ready;

  // Coordinates: mix of full range, near zero and rails.
  function automatic logic [IN_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 20'h80000;
      1: return 20'h7FFFF;
      2, 3: return IN_W'($urandom_range(0, 4095) - 2048);
      default: return IN_W'($urandom);
    endcase
  endfunction

  function automatic swing_req_t rand_req();
    swing_req_t r;
    for (int i = 0; i < 3; i++) begin
      r.s[i] = rand_coord();
      r.m[i] = rand_coord();
      r.e[i] = rand_coord();
    end
    // occasionally a zero chord on either segment
    if ($urandom_range(0, 15) == 0) r.m = r.s;
    if ($urandom_range(0, 15) == 0) r.e = r.m;
    case ($urandom_range(0, 7))
      0: r.ph = PH_W'($urandom);                // full 17 bits, clamp above one
      1: r.ph = PH_W'(PHASE_HALF + $urandom_range(0, 2) - 1);
      default: r.ph = PH_W'($urandom_range(0, 65536));
    endcase
    r.lg = LEG_W'($urandom);
    return r;
  endfunction

  // Offer one item; the sender idles between bursts of random length.
  task automatic send_item(swing_req_t r);
    if (burst_left == 0) begin
      in_valid = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    start_x = r.s[0]; start_y = r.s[1]; start_z = r.s[2];
    mid_x   = r.m[0]; mid_y   = r.m[1]; mid_z   = r.m[2];
    end_x   = r.e[0]; end_y   = r.e[1]; end_z   = r.e[2];
    phase = r.ph;
    leg = r.lg;
    in_valid = 1;
    do @(negedge clk); while (!in_taken);
    burst_left--;
    n_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we = 1;
    cfg_idx = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // Wait until every predicted point has come back, then let the pipe drain.
  task automatic drain();
    in_valid = 0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_all(logic [DIR_W-1:0] d0, logic [DIR_W-1:0] d1, logic [DIR_W-1:0] d2,
                           logic [DIR_W-1:0] d3, logic [HR_W-1:0] hf, logic [LR_W-1:0] lf,
                           logic [HR_W-1:0] hh, logic [LR_W-1:0] lh);
    write_reg(REG_FRONT_DIR1, d0);
    write_reg(REG_FRONT_DIR2, d1);
    write_reg(REG_HIND_DIR1, d2);
    write_reg(REG_HIND_DIR2, d3);
    write_reg(REG_FRONT_HANDLE, CFG_W'(hf));
    write_reg(REG_FRONT_LIFT, CFG_W'(lf));
    write_reg(REG_HIND_HANDLE, CFG_W'(hh));
    write_reg(REG_HIND_LIFT, CFG_W'(lh));
  endtask

  // Receiver: the stall pattern is picked at random from three modes; one long hold fills the pipe.
  initial begin
    int mode;
    int cyc;
    mode = 0;
    cyc = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      cyc++;
      if (stall_left > 0) begin
        out_ready = 0;
        stall_left--;
      end else if (!long_stall_done && n_sent >= 600) begin
        long_stall_done = 1;
        stall_left = 400;
        out_ready = 0;
      end else begin
        if (cyc % 50 == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_ready = 1;
          1: out_ready = ($urandom_range(0, 1) == 1);
          default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    swing_req_t r;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed items at reset settings.
    for (int k = 0; k < 20; k++) begin
      r = rand_req();
      r.lg = k[1:0];
      case (k)
        0: begin r.ph = 17'd0; end
        1: begin r.ph = 17'd32767; end
        2: begin r.ph = PHASE_HALF; end
        3: begin r.ph = 17'd65535; end
        4: begin r.ph = PHASE_ONE; end
        5: begin r.ph = 17'h1FFFF; end
        6: begin r.ph = 17'd70000; end
        7, 8: begin
          for (int i = 0; i < 3; i++) begin
            r.s[i] = 20'h80000; r.m[i] = 20'h7FFFF; r.e[i] = 20'h80000;
          end
          r.ph = (k == 7) ? 17'd16384 : 17'd49152;
        end
        9: begin r.m = r.s; r.ph = 17'd10000; end     // zero chord, segment one
        10: begin r.e = r.m; r.ph = 17'd50000; end    // zero chord, segment two
        11: begin
          for (int i = 0; i < 3; i++) begin r.s[i] = '0; r.m[i] = '0; r.e[i] = '0; end
        end
        default: ;
      endcase
      send_item(r);
    end
    drain();

    // Register phases: zeros, maxima, odd lanes and handle above one, then random.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: write_all('0, '0, '0, '0, '0, '0, '0, '0);
        1: write_all({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
                     15'd16384, 16'hFFFF, 15'd16384, 16'hFFFF);
        2: write_all(48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, 48'h2D41_0000_D2BF,
                     48'h4000_4000_4000, 15'h7FFF, 16'hFFFF, 15'h7FFF, 16'd1);
        3: write_all(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h0000_7FFF_0000,
                     48'h8000_0000_8000, 15'd16384, 16'hFFFF, 15'd0, 16'hFFFF);
        default: write_all(DIR_W'({$urandom, $urandom}), DIR_W'({$urandom, $urandom}),
                           DIR_W'({$urandom, $urandom}), DIR_W'({$urandom, $urandom}),
                           HR_W'($urandom_range(0, 16384)), LR_W'($urandom),
                           HR_W'($urandom), LR_W'($urandom));
      endcase
      repeat (250) send_item(rand_req());
      drain();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit, well above the slowest legal run.
  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sbt_pkg.sv
rtl/sbt_isqrt.sv
rtl/swing_bezier_trajectory_point.sv
verif/sbt_point_checker.sv
verif/tb_swing_bezier_trajectory_point.sv
